FILE: hdl/crc32ic_pkg.sv
// ----------------------------------------------------------------------------
// crc32ic_pkg
// shared constants and the byte fold for the reflected crc-32 checker
// ----------------------------------------------------------------------------
package crc32ic_pkg;

    localparam int unsigned CRC_WIDTH  = 32;
    localparam int unsigned BYTE_WIDTH = 8;

    localparam logic [CRC_WIDTH-1:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CRC_WIDTH-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [CRC_WIDTH-1:0] CODE_NONE    = 32'h0000_0000;

    typedef logic [CRC_WIDTH-1:0]  crc_t;
    typedef logic [BYTE_WIDTH-1:0] byte_t;

    // fold one byte into the running crc, lsb first
    function automatic crc_t crc_fold_byte(input crc_t crc, input byte_t data);
        crc_t c;
        c = {24'h00_0000, crc[7:0] ^ data};
        for (int k = 0; k < BYTE_WIDTH; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c ^ (crc >> BYTE_WIDTH);
    endfunction

endpackage

FILE: hdl/crc32_integrity_checker.sv
// ----------------------------------------------------------------------------
// crc32_integrity_checker
// streaming reflected crc-32 with check code compare and sticky error report
// ----------------------------------------------------------------------------
// usage
//   input channel: data_byte and last_byte with in_valid / in_stall; a request
//   is taken at a clock edge with in_valid high and in_stall low
//   output channel: one result request per stream, on its last byte, carrying
//   crc_value, corrupt and first_report with out_valid / out_stall
//   config channel: expected_code with cfg_valid / cfg_ready, always ready;
//   write it only while no stream is in flight; zero disables the compare
//   path: a last byte goes through the input register, then fold and compare
//   into the result register; it waits in the input register while a result is held
//   throughput: one byte per cycle unless a last byte stalls, set by the single
//   byte-wide fold between the input register and the crc/result registers
//   stall: while out_stall holds a result, a further byte that is not last
//   still flows; a last byte waits in the input register and in_stall rises
//   reset: running crc returns to all ones, sticky report flag and the
//   expected code clear, both channels go empty
// ----------------------------------------------------------------------------
module crc32_integrity_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  in_valid,
    output logic                  in_stall,
    input  crc32ic_pkg::byte_t    data_byte,
    input  logic                  last_byte,
    // result stream
    output logic                  out_valid,
    input  logic                  out_stall,
    output crc32ic_pkg::crc_t     crc_value,
    output logic                  corrupt,
    output logic                  first_report,
    // config write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  crc32ic_pkg::crc_t     expected_code
);
    import crc32ic_pkg::*;

    // input register
    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // running state
    crc_t  crc_reg;
    crc_t  crc_next;
    logic  reported_reg;
    logic  reported_next;
    crc_t  expected_reg;

    // result register
    logic  out_valid_reg;
    logic  out_valid_next;
    crc_t  res_crc_reg;
    logic  res_corrupt_reg;
    logic  res_first_reg;

    logic  out_free;
    logic  proc;
    logic  in_take;
    crc_t  crc_fold;
    crc_t  crc_final;
    logic  mismatch;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // the held byte moves on unless it is a last byte with no room for its result
    assign proc     = in_valid_reg && (!in_last_reg || out_free);
    assign in_stall = in_valid_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    assign crc_fold  = crc_fold_byte(crc_reg, in_byte_reg);
    assign crc_final = ~crc_fold;
    assign mismatch  = (expected_reg != CODE_NONE) && (expected_reg != crc_final);

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        crc_next       = crc_reg;
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
        if (proc)
        begin
            if (in_last_reg)
            begin
                crc_next       = CRC_ALL_ONES;
                reported_next  = reported_reg || mismatch;
                out_valid_next = 1'b1;
            end
            else
            begin
                crc_next = crc_fold;
            end
        end
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_ALL_ONES;
            reported_reg  <= 1'b0;
            expected_reg  <= CODE_NONE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            reported_reg  <= reported_next;
            if (cfg_valid && cfg_ready)
            begin
                expected_reg <= expected_code;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (proc && in_last_reg)
        begin
            res_crc_reg     <= crc_final;
            res_corrupt_reg <= reported_reg || mismatch;
            res_first_reg   <= !reported_reg && mismatch;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign crc_value    = res_crc_reg;
    assign corrupt      = res_corrupt_reg;
    assign first_report = res_first_reg;

endmodule

FILE: hdl/crc32ic_checker.sv
// ----------------------------------------------------------------------------
// crc32ic_checker
// port-level checks of the crc-32 checker, bound to the top level
// ----------------------------------------------------------------------------
module crc32ic_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input crc32ic_pkg::crc_t  crc_value,
    input logic               corrupt,
    input logic               first_report
);
    import crc32ic_pkg::*;

    // a first report has been delivered
    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && first_report)
        begin
            seen_reg <= 1'b1;
        end
    end

    // a held result stays offered with the same crc
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(crc_value))
        else $error("held result dropped or changed");

    // a report pulse always comes with a corrupt verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_report |-> corrupt)
        else $error("first report without corrupt");

    // only one report pulse ever
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> !first_report)
        else $error("second first report");

    // once reported, every later verdict is corrupt
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> corrupt)
        else $error("sticky report lost");

    // input side only backs up when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result slot");

endmodule

bind crc32_integrity_checker crc32ic_checker u_crc32ic_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .crc_value    (crc_value),
    .corrupt      (corrupt),
    .first_report (first_report)
);

FILE: tb/crc32_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc32_result_checker
// watches the byte, result and config channels of the crc-32 checker, keeps
// its own crc and sticky report state and compares every result request
// ----------------------------------------------------------------------------
module crc32_result_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  crc32ic_pkg::byte_t    data_byte,
    input  logic                  last_byte,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  crc32ic_pkg::crc_t     crc_value,
    input  logic                  corrupt,
    input  logic                  first_report,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  crc32ic_pkg::crc_t     expected_code,
    output int                    errors,
    output int                    pending
);

    import crc32ic_pkg::*;

    typedef struct packed
    {
        crc_t crc;
        logic corrupt;
        logic first_rep;
    } verdict_t;

    verdict_t verdict_q[$];
    crc_t     run_crc;
    logic     sticky;
    crc_t     check_code;

    // one bit per step, data bit mixed into the low crc bit
    function automatic crc_t fold_byte_bits(input crc_t c, input byte_t d);
        crc_t r;
        r = c;
        for (int i = 0; i < BYTE_WIDTH; i++)
        begin
            if (r[0] ^ d[i])
            begin
                r = (r >> 1) ^ CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input crc_t got, input crc_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        crc_t     fin;
        logic     miss;
        if (!rst_n)
        begin
            errors     = 0;
            run_crc    = CRC_ALL_ONES;
            sticky     = 1'b0;
            check_code = CODE_NONE;
            verdict_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                check_code = expected_code;
            end
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result with none expected", crc_value, '0);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (crc_value !== want.crc)
                        report_mismatch("crc_value", crc_value, want.crc);
                    if (corrupt !== want.corrupt)
                        report_mismatch("corrupt", crc_t'(corrupt), crc_t'(want.corrupt));
                    if (first_report !== want.first_rep)
                        report_mismatch("first_report", crc_t'(first_report),
                                        crc_t'(want.first_rep));
                end
            end
            if (in_valid && !in_stall)
            begin
                run_crc = fold_byte_bits(run_crc, data_byte);
                if (last_byte)
                begin
                    fin     = ~run_crc;
                    run_crc = CRC_ALL_ONES;
                    miss    = (check_code != CODE_NONE) && (check_code != fin);
                    verdict_q.push_back('{crc: fin, corrupt: sticky | miss,
                                          first_rep: !sticky && miss});
                    if (miss)
                    begin
                        sticky = 1'b1;
                    end
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

FILE: tb/crc32_integrity_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc32_integrity_checker_test
// drives byte streams and check code writes into the crc-32 checker under
// random idling on both channels; a side checker predicts every result
// ----------------------------------------------------------------------------
module crc32_integrity_checker_test;

    import crc32ic_pkg::*;

    // receiver hold-off long enough for a held result plus a waiting last byte
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    // settle time after the last result, lets the input and result registers drain
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PHASE_BYTES     = 520;
    localparam int unsigned CHUNK_BYTES     = 100;
    // well known crc-32 values: ascii "123456789" and a single zero byte
    localparam crc_t CHECK_DIGITS    = 32'hCBF4_3926;
    localparam crc_t CHECK_ZERO_BYTE = 32'hD202_EF8D;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    byte_t data_byte;
    logic  last_byte;
    logic  out_valid;
    logic  out_stall;
    crc_t  crc_value;
    logic  corrupt;
    logic  first_report;
    logic  cfg_valid;
    logic  cfg_ready;
    crc_t  expected_code;

    int errors;
    int pending;

    // idle chances in percent per cycle, changed between phases
    int send_idle_pct = 25;
    int recv_idle_pct = 72;
    // bumped by the stimulus to start one long receiver hold-off
    int hold_req      = 0;
    int bytes_sent    = 0;

    crc32_integrity_checker uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .crc_value     (crc_value),
        .corrupt       (corrupt),
        .first_report  (first_report),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .expected_code (expected_code)
    );

    crc32_result_checker result_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .crc_value     (crc_value),
        .corrupt       (corrupt),
        .first_report  (first_report),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .expected_code (expected_code),
        .errors        (errors),
        .pending       (pending)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stall, or a long hold-off counted here when requested
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_seen = hold_req;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // one byte request; idle cycles come first so the payload never moves
    // while it waits out in_stall
    task automatic send_byte(input byte_t d, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // ascii digits 1..9, the standard crc-32 check string
    task automatic send_digits();
        for (int i = 0; i < 9; i++)
        begin
            send_byte(byte_t'(8'h31 + i), i == 8);
        end
    endtask

    // mostly short streams so results come often, some longer ones
    task automatic send_random_stream();
        int len;
        len = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        for (int i = 1; i <= len; i++)
        begin
            send_byte(byte_t'($urandom), i == len);
        end
    endtask

    task automatic random_phase(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            send_random_stream();
        end
    endtask

    // drop valid, wait for every predicted result, then let the pipe drain
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // check code writes only happen with no stream in flight
    task automatic write_code(input crc_t code);
        settle();
        cfg_valid     <= 1'b1;
        expected_code <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        last_byte     = 1'b0;
        cfg_valid     = 1'b0;
        expected_code = CODE_NONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // compare disabled after reset: byte extremes and the check string
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_digits();

        // matching check code gives a clean verdict
        write_code(CHECK_DIGITS);
        send_digits();

        // random streams with the compare off, sender 25 / receiver 72
        write_code(CODE_NONE);
        hold_req++;
        random_phase(PHASE_BYTES);

        // sender 72 / receiver 25
        send_idle_pct = 72;
        recv_idle_pct = 25;
        random_phase(PHASE_BYTES);

        // all-ones code mismatches: first report, then a repeat mismatch
        write_code(CRC_ALL_ONES);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b1);
        // sticky flag survives a disabled compare and a matching code
        write_code(CODE_NONE);
        send_byte(8'h00, 1'b1);
        write_code(CHECK_ZERO_BYTE);
        send_byte(8'h00, 1'b1);

        // no idling, random codes per chunk with the compare off in the last, long hold-off to fill the pipe
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 5; k++)
        begin
            write_code((k == 4) ? CODE_NONE : crc_t'($urandom));
            if (k == 0)
            begin
                hold_req++;
            end
            random_phase(CHUNK_BYTES);
        end

        settle();
        if (errors == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/crc32ic_pkg.sv
hdl/crc32_integrity_checker.sv
hdl/crc32ic_checker.sv
tb/crc32_result_checker.sv
tb/crc32_integrity_checker_test.sv
